FILE: rtl/vtd_pkg.sv
package vtd_pkg;

  // Table geometry
  localparam int unsigned MAX_UNIQUE = 4096;
  localparam int unsigned REF_BITS   = 20;
  localparam int unsigned ADDR_W     = $clog2(MAX_UNIQUE);
  localparam int unsigned CNT_W      = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned ENTRY_W    = 3 * REF_BITS;

  // Fixed field widths of the channels
  localparam int unsigned REF_IN_W = 21;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                first_of_mesh;
    logic [REF_IN_W-1:0] pos_ref;
    logic [REF_IN_W-1:0] tex_ref;
    logic [REF_IN_W-1:0] norm_ref;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   vertex_slot;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture the incoming corner
    logic step;      // issue the next table read
    logic finish;    // settle the result, append on a miss while the table has room
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;      // search has hit or run past the last stored entry
    logic out_free;  // output register can take a result this cycle
  } sts_t;

  // 1-based reference to 0-based, wrapped to REF_BITS
  function automatic logic [REF_BITS-1:0] to_zero_based(input logic [REF_IN_W-1:0] ref_v);
    logic [REF_BITS-1:0] low_bits;
    low_bits = ref_v[REF_BITS-1:0];
    return low_bits - REF_BITS'(1);
  endfunction

endpackage

FILE: rtl/vertex_triple_dedup_core.sv
// Search: each transaction reads the stored table entries in insertion order until the first
//   match, or through all stored entries on a miss, via the single read port of the triple
//   table, read once per cycle. A new transaction is accepted only once the previous
//   result has moved into the output register.
// Reset: asynchronous, active low; empties the table (entry count to zero), idles the
//   controller and drops the output valid. Table contents are not cleared.
module vertex_triple_dedup_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vtd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vtd_pkg::out_t out_data_o
);
  import vtd_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // Controller: idle, search (one table read per cycle, the registered read data compared with the key),
  // then hold the settled result until the output register is free.
  vtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: key register, triple table, entry count, read pointer and the output
  // register. The output register lets a new transaction be accepted while the
  // previous result still waits downstream.
  vtd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/vtd_ctrl.sv
module vtd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vtd_pkg::sts_t sts_i,
  output vtd_pkg::cmd_t cmd_o
);
  import vtd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/vtd_dp.sv
module vtd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vtd_pkg::cmd_t cmd_i,
  output vtd_pkg::sts_t sts_o,
  input  vtd_pkg::in_t  in_data_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output vtd_pkg::out_t out_data_o
);
  import vtd_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_UNIQUE];

  logic [ENTRY_W-1:0] key_q;
  logic [ENTRY_W-1:0] rd_data_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic               cmp_valid_q, cmp_valid_d;
  logic [ADDR_W-1:0]  cmp_idx_q;
  out_t               res_q, res_d;
  out_t               out_q;
  logic               out_valid_q, out_valid_d;

  logic hit;
  logic has_room;
  logic append;

  assign hit      = cmp_valid_q && (rd_data_q == key_q);
  assign has_room = count_q < CNT_W'(MAX_UNIQUE);
  assign append   = cmd_i.finish && !hit && has_room;

  assign sts_o.done     = hit || (rd_ptr_q == count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_valid_d = cmp_valid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.accept) begin
      rd_ptr_d    = '0;
      cmp_valid_d = 1'b0;
      if (in_data_i.first_of_mesh) begin
        count_d = '0;
      end
    end
    if (cmd_i.step) begin
      rd_ptr_d    = rd_ptr_q + CNT_W'(1);
      cmp_valid_d = 1'b1;
    end
    if (cmd_i.finish) begin
      cmp_valid_d = 1'b0;
    end
    if (append) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    priority if (hit) begin
      res_d.vertex_slot = SLOT_W'(cmp_idx_q);
      res_d.status      = STATUS_MATCH;
    end else if (has_room) begin
      res_d.vertex_slot = SLOT_W'(count_q);
      res_d.status      = STATUS_NEW;
    end else begin
      res_d.vertex_slot = '0;
      res_d.status      = STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= {to_zero_based(in_data_i.pos_ref),
                to_zero_based(in_data_i.tex_ref),
                to_zero_based(in_data_i.norm_ref)};
    end
    if (cmd_i.step) begin
      cmp_idx_q <= rd_ptr_q[ADDR_W-1:0];
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  // Triple table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (append) begin
      mem[count_q[ADDR_W-1:0]] <= key_q;
    end
    if (cmd_i.step) begin
      rd_data_q <= mem[rd_ptr_q[ADDR_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/vtd_chk.sv
module vtd_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input vtd_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input vtd_pkg::out_t out_data_o
);
  import vtd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_MATCH ||
                     out_data_o.status == STATUS_NEW ||
                     out_data_o.status == STATUS_FULL))
    else $error("undefined status code");

  // A dropped corner reports slot zero
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_FULL |-> out_data_o.vertex_slot == '0)
    else $error("dropped corner with non-zero slot");

  // An accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while search in progress");

endmodule

bind vertex_triple_dedup_core vtd_chk u_vtd_chk (.*);
